// ===== hdl/jcs_pkg.sv =====
// Shared word types and the regex lead-byte decoder for the comment stripper.
`default_nettype none

package jcs_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } jcs_in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } jcs_out_word_t;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } jcs_lex_result_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] RESET_LAST = 8'h3B;

    function automatic logic is_regex_lead(input logic [7:0] b);
        logic r;
        begin
            unique case (b) inside
                8'h28, 8'h2C, 8'h3D, 8'h3A, 8'h5B, 8'h21, 8'h26, 8'h7C, 8'h3F, 8'h7B,
                8'h7D, 8'h3B, 8'h2B, 8'h2A, 8'h25, 8'h7E, 8'h5E, 8'h3C, 8'h3E: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/js_comment_stripper.sv =====
// Top level of the streaming JavaScript comment stripper.
//
// Source text enters on the text channel one byte per word, with stream_end
// set on the final byte of a source. Stripped bytes leave on the result
// channel; run_last marks the last result word caused by one source byte.
// Both channels use valid and stall, and a word moves on a rising edge where
// valid is high and stall is low.
// An accepted byte is held in the input register, is lexed into a four-word
// output queue once the queue has room, and its first result is then offered
// from the head of the queue on the result channel.
// One source byte is taken every cycle while the queue holds at most two
// words; a byte makes zero, one or two result words, and the result channel
// moves one word per cycle, so bursts of two-word bytes are paced by it.
// When the receiver stalls the queue fills and the text channel stalls in
// turn; no word is lost. Reset clears the lexer to code mode and empties the
// queue and the input register.
`default_nettype none

module js_comment_stripper
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      text_valid,
    output logic                     text_stall,
    input  wire jcs_pkg::jcs_in_word_t text_word,
    output logic                     result_valid,
    input  wire                      result_stall,
    output jcs_pkg::jcs_out_word_t   result_word
);
    import jcs_pkg::*;

    logic            in_valid_reg;
    jcs_in_word_t    in_word_reg;
    logic            room;
    logic            advance;
    jcs_lex_result_t lex_result;

    assign advance    = in_valid_reg && room;
    assign text_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!text_stall)
            in_valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
            in_word_reg <= text_word;
    end

    jcs_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .result  (lex_result)
    );

    jcs_out_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (advance),
        .result (lex_result),
        .room   (room),
        .valid  (result_valid),
        .stall  (result_stall),
        .word   (result_word)
    );

endmodule

`default_nettype wire

// ===== hdl/jcs_lexer.sv =====
// Lexer state registers and the per-byte next-state and output logic.
`default_nettype none

module jcs_lexer
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    advance,
    input  wire jcs_pkg::jcs_in_word_t word,
    output jcs_pkg::jcs_lex_result_t result
);
    import jcs_pkg::*;

    localparam logic [2:0] MODE_CODE  = 3'd0;
    localparam logic [2:0] MODE_DQ    = 3'd1;
    localparam logic [2:0] MODE_SQ    = 3'd2;
    localparam logic [2:0] MODE_TMPL  = 3'd3;
    localparam logic [2:0] MODE_LINE  = 3'd4;
    localparam logic [2:0] MODE_BLOCK = 3'd5;
    localparam logic [2:0] MODE_REGEX = 3'd6;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_TICK  = 8'h60;

    logic [2:0] mode_reg, mode_next;
    logic       held_reg, held_next;
    logic       star_reg, star_next;
    logic       esc_reg, esc_next;
    logic [7:0] last_reg, last_next;

    logic [7:0] c;
    logic [7:0] closer;
    logic       lit;
    logic       nl_ends;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;

    assign c = word.in_byte;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        star_next = star_reg;
        esc_next  = esc_reg;
        last_next = last_reg;
        cnt       = 2'd0;
        b0        = 8'h00;
        b1        = 8'h00;
        lit       = 1'b0;
        nl_ends   = 1'b0;
        closer    = CH_SLASH;

        unique case (mode_reg)
            MODE_DQ:
            begin
                lit    = 1'b1;
                closer = CH_DQ;
            end
            MODE_SQ:
            begin
                lit    = 1'b1;
                closer = CH_SQ;
            end
            MODE_TMPL:
            begin
                lit    = 1'b1;
                closer = CH_TICK;
            end
            MODE_REGEX:
            begin
                lit     = 1'b1;
                nl_ends = 1'b1;
            end
            MODE_LINE:
            begin
                if (c == CH_LF)
                begin
                    mode_next = MODE_CODE;
                    b0        = CH_LF;
                    cnt       = 2'd1;
                    last_next = CH_LF;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && c == CH_SLASH)
                begin
                    star_next = 1'b0;
                    mode_next = MODE_CODE;
                end
                else
                begin
                    star_next = (c == CH_STAR);
                    if (c == CH_LF)
                    begin
                        b0        = CH_LF;
                        cnt       = 2'd1;
                        last_next = CH_LF;
                    end
                end
            end
            default:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (c == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (c == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        b0        = CH_SLASH;
                        cnt       = 2'd1;
                        last_next = CH_SLASH;
                        if (is_regex_lead(last_reg))
                        begin
                            mode_next = MODE_REGEX;
                            lit       = 1'b1;
                            nl_ends   = 1'b1;
                        end
                    end
                end
                else if (c == CH_SLASH && !word.stream_end)
                begin
                    held_next = 1'b1;
                end
                else if (c == CH_SLASH)
                begin
                    b0        = CH_SLASH;
                    cnt       = 2'd1;
                    last_next = CH_SLASH;
                end

                // A code byte that is not part of a slash sequence.
                if (!lit && c != CH_SLASH && !(held_reg && c == CH_STAR))
                begin
                    if (c == CH_DQ)
                        mode_next = MODE_DQ;
                    else if (c == CH_SQ)
                        mode_next = MODE_SQ;
                    else if (c == CH_TICK)
                        mode_next = MODE_TMPL;
                    if (cnt == 2'd0)
                        b0 = c;
                    else
                        b1 = c;
                    cnt       = cnt + 2'd1;
                    last_next = c;
                end
            end
        endcase

        // Literal bytes: strings, templates and regexes are copied verbatim.
        if (lit)
        begin
            if (cnt == 2'd0)
                b0 = c;
            else
                b1 = c;
            cnt       = cnt + 2'd1;
            last_next = c;
            if (esc_reg)
                esc_next = 1'b0;
            else if (c == CH_BSL)
                esc_next = 1'b1;
            else if (c == closer || (nl_ends && c == CH_LF))
                mode_next = MODE_CODE;
        end

        if (word.stream_end)
        begin
            mode_next = MODE_CODE;
            held_next = 1'b0;
            star_next = 1'b0;
            esc_next  = 1'b0;
            last_next = RESET_LAST;
        end
    end

    assign result.count = cnt;
    assign result.byte0 = b0;
    assign result.byte1 = b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CODE;
            held_reg <= 1'b0;
            star_reg <= 1'b0;
            esc_reg  <= 1'b0;
            last_reg <= RESET_LAST;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            star_reg <= star_next;
            esc_reg  <= esc_next;
            last_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jcs_out_queue.sv =====
// Shift queue that takes up to two result words per cycle and emits one unless stalled.
`default_nettype none

module jcs_out_queue
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  wire jcs_pkg::jcs_lex_result_t result,
    output logic                     room,
    output logic                     valid,
    input  wire                      stall,
    output jcs_pkg::jcs_out_word_t   word
);
    import jcs_pkg::*;

    jcs_out_word_t         data_reg [QUEUE_DEPTH];
    jcs_out_word_t         data_next [QUEUE_DEPTH];
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic [QUEUE_CW-1:0]   base;
    logic [QUEUE_CW-1:0]   n_push;
    logic                  pop;
    jcs_out_word_t         w0;
    jcs_out_word_t         w1;

    assign valid = (count_reg != '0);
    assign word  = data_reg[0];
    assign pop   = valid && !stall;
    assign room  = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));

    assign n_push = push ? QUEUE_CW'(result.count) : '0;
    assign base   = count_reg - QUEUE_CW'(pop);

    assign w0.out_byte = result.byte0;
    assign w0.run_last = (result.count == 2'd1);
    assign w1.out_byte = result.byte1;
    assign w1.run_last = 1'b1;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
                data_next[i] = data_reg[(i + 1) % QUEUE_DEPTH];
            else
                data_next[i] = data_reg[i];
            if (n_push != '0 && base == QUEUE_CW'(i))
                data_next[i] = w0;
            if (n_push == QUEUE_CW'(2) && base + QUEUE_CW'(1) == QUEUE_CW'(i))
                data_next[i] = w1;
        end
        count_next = base + n_push;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            data_reg[i] <= data_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire
